FILE: rtl/core/tnss_pkg.sv
// shared types and constants for the top-n score selector
`default_nettype none

package tnss_pkg;

  // fixed field widths
  localparam int SCORE_W     = 8;
  localparam int KEEP_W      = 4;
  localparam int MIN_W       = 9;
  localparam int OUT_INDEX_W = 16;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  // register reset values
  localparam logic [KEEP_W-1:0] KEEP_COUNT_RESET = 4'd3;
  localparam logic [MIN_W-1:0]  MIN_SCORE_RESET  = 9'd26;

  // register map, word index
  typedef enum logic [0:0] {
    REG_KEEP_COUNT = 1'b0,
    REG_MIN_SCORE  = 1'b1
  } reg_idx_t;

  // configuration seen by the datapath
  typedef struct packed {
    logic [KEEP_W-1:0] keep_count;
    logic [MIN_W-1:0]  min_score;
  } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/core/top_n_score_selector_core.sv
// top level of the top-n score selector
//
//  channel   direction  handshake                     payload
//  request   in         start & !busy                 score, is_last
//  result    out        strobe (one cycle, no stall)  top_score, class_index, final_entry
//  config    in         apb write, psel&penable&pwrite  keep_count @0x0, min_score @0x4
//
// one score request per cycle while busy is low; each insertion into the sorted table is a
// single parallel compare-and-shift; after a request with is_last, the n kept entries come out
// back to back in rank order through the drain state and the result register; busy comes from
// the drain sequencer and falls by the final result; an empty set gives no results, no busy
// rst is synchronous: table count, position, drain state, config registers and result strobe
// return to reset values; the result side cannot stall, so results are never held back
`default_nettype none

module top_n_score_selector_core #(
  parameter int TABLE_DEPTH = 8,
  parameter int INDEX_BITS  = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [tnss_pkg::SCORE_W-1:0]       score,
  input  wire logic                               is_last,
  output logic                                    strobe,
  output logic      [tnss_pkg::SCORE_W-1:0]       top_score,
  output logic      [tnss_pkg::OUT_INDEX_W-1:0]   class_index,
  output logic                                    final_entry,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [tnss_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [tnss_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [tnss_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                    pready
);
  import tnss_pkg::*;

  localparam int KEY_W = SCORE_W + INDEX_BITS;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  cfg_t             cfg;
  logic             accept;
  logic [IDX_W-1:0] rd_idx;
  logic [KEY_W-1:0] rd_key;
  logic [CNT_W-1:0] end_count;

  assign accept = start && !busy;

  // configuration registers
  tnss_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sorted best-entry table
  tnss_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .INDEX_BITS  (INDEX_BITS)
  ) u_table (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .score     (score),
    .is_last   (is_last),
    .rd_idx    (rd_idx),
    .rd_key    (rd_key),
    .end_count (end_count)
  );

  // result sequencer
  tnss_drain #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .INDEX_BITS  (INDEX_BITS)
  ) u_drain (
    .clk         (clk),
    .rst         (rst),
    .go          (accept && is_last),
    .go_count    (end_count),
    .rd_key      (rd_key),
    .rd_idx      (rd_idx),
    .draining    (busy),
    .strobe      (strobe),
    .top_score   (top_score),
    .class_index (class_index),
    .final_entry (final_entry)
  );

endmodule

`default_nettype wire

FILE: rtl/core/tnss_cfg.sv
// apb register block holding keep_count and min_score
`default_nettype none

module tnss_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [tnss_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [tnss_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [tnss_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                    pready,
  output tnss_pkg::cfg_t                          cfg
);
  import tnss_pkg::*;

  reg_idx_t reg_idx;
  logic     wr_en;

  assign reg_idx = reg_idx_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.keep_count <= KEEP_COUNT_RESET;
      cfg.min_score  <= MIN_SCORE_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_KEEP_COUNT: cfg.keep_count <= pwdata[KEEP_W-1:0];
        REG_MIN_SCORE:  cfg.min_score  <= pwdata[MIN_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_KEEP_COUNT: prdata = APB_DATA_W'(cfg.keep_count);
      REG_MIN_SCORE:  prdata = APB_DATA_W'(cfg.min_score);
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/tnss_table.sv
// sorted table of best (score, index) keys with parallel insert
`default_nettype none

module tnss_table #(
  parameter int TABLE_DEPTH = 8,
  parameter int INDEX_BITS  = 16,
  localparam int KEY_W = tnss_pkg::SCORE_W + INDEX_BITS,
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1),
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire tnss_pkg::cfg_t                cfg,
  input  wire logic                          accept,
  input  wire logic [tnss_pkg::SCORE_W-1:0]  score,
  input  wire logic                          is_last,
  input  wire logic [IDX_W-1:0]              rd_idx,
  output logic      [KEY_W-1:0]              rd_key,
  output logic      [CNT_W-1:0]              end_count
);
  import tnss_pkg::*;

  localparam int KW = (CNT_W > KEEP_W) ? CNT_W : KEEP_W;

  logic [KEY_W-1:0]      entry     [TABLE_DEPTH];
  logic [KEY_W-1:0]      entry_next[TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] ge;
  logic [CNT_W-1:0]      cnt;
  logic [CNT_W-1:0]      cnt_trim;
  logic [CNT_W-1:0]      cnt_after;
  logic [CNT_W-1:0]      keep_eff;
  logic [KW-1:0]         keep_ext;
  logic [INDEX_BITS-1:0] pos;
  logic [KEY_W-1:0]      key;
  logic                  pass;
  logic                  insert;

  // effective keep count, saturated at table depth
  assign keep_ext = KW'(cfg.keep_count);
  assign keep_eff = (keep_ext > KW'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : CNT_W'(keep_ext);

  assign key      = {score, pos};
  assign pass     = {1'b0, score} >= cfg.min_score;
  assign insert   = accept && pass && (keep_eff != '0);
  assign cnt_trim = (cnt > keep_eff) ? keep_eff : cnt;

  // count after this request, before the vector end clears it
  always_comb begin
    cnt_after = cnt;
    if (accept && pass) begin
      if (keep_eff == '0)
        cnt_after = '0;
      else if (cnt_trim < keep_eff)
        cnt_after = cnt_trim + 1'b1;
      else
        cnt_after = cnt_trim;
    end
  end

  assign end_count = (cnt_after > keep_eff) ? keep_eff : cnt_after;

  // parallel compare and shift: entries ranking at or above the key stay,
  // the key lands in the first slot below them, the rest move down one
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_slot
    assign ge[i] = (CNT_W'(i) < cnt_trim) && (entry[i] >= key);
    if (i == 0) begin : g_head
      assign entry_next[i] = ge[i] ? entry[i] : key;
    end else begin : g_body
      assign entry_next[i] = ge[i]     ? entry[i]   :
                             ge[i - 1] ? key        : entry[i - 1];
    end
  end

  // table payload
  always_ff @(posedge clk) begin
    if (insert) begin
      for (int i = 0; i < TABLE_DEPTH; i++)
        entry[i] <= entry_next[i];
    end
  end

  // fill count and running position
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      pos <= '0;
    end else if (accept) begin
      if (is_last) begin
        cnt <= '0;
        pos <= '0;
      end else begin
        cnt <= cnt_after;
        pos <= pos + 1'b1;
      end
    end
  end

  assign rd_key = entry[rd_idx];

endmodule

`default_nettype wire

FILE: rtl/core/tnss_drain.sv
// walks the kept entries out in rank order into the result register
`default_nettype none

module tnss_drain #(
  parameter int TABLE_DEPTH = 8,
  parameter int INDEX_BITS  = 16,
  localparam int KEY_W = tnss_pkg::SCORE_W + INDEX_BITS,
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1),
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              go,
  input  wire logic [CNT_W-1:0]                  go_count,
  input  wire logic [KEY_W-1:0]                  rd_key,
  output logic      [IDX_W-1:0]                  rd_idx,
  output logic                                   draining,
  output logic                                   strobe,
  output logic      [tnss_pkg::SCORE_W-1:0]      top_score,
  output logic      [tnss_pkg::OUT_INDEX_W-1:0]  class_index,
  output logic                                   final_entry
);
  import tnss_pkg::*;

  logic [CNT_W-1:0] total;
  logic             at_end;

  assign at_end = (CNT_W'(rd_idx) + 1'b1) == total;

  // drain sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      draining <= 1'b0;
      rd_idx   <= '0;
      total    <= '0;
    end else if (draining) begin
      if (at_end)
        draining <= 1'b0;
      rd_idx <= rd_idx + 1'b1;
    end else if (go && (go_count != '0)) begin
      draining <= 1'b1;
      rd_idx   <= '0;
      total    <= go_count;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst)
      strobe <= 1'b0;
    else
      strobe <= draining;
  end

  always_ff @(posedge clk) begin
    top_score   <= rd_key[KEY_W-1 -: SCORE_W];
    class_index <= OUT_INDEX_W'(rd_key[INDEX_BITS-1:0]);
    final_entry <= at_end;
  end

endmodule

`default_nettype wire

FILE: rtl/core/tnss_checker.sv
// port-level checks for the top-n score selector, bound to the top level
`default_nettype none

module tnss_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic is_last,
  input wire logic strobe,
  input wire logic final_entry
);

  // results come only out of a drain
  a_no_result_when_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |=> !strobe)
    else $error("result strobe without a preceding busy cycle");

  // a non-final result is followed directly by another one
  a_results_back_to_back: assert property (@(posedge clk) disable iff (rst)
    strobe && !final_entry |=> strobe)
    else $error("gap inside a result burst");

  // busy stays high until the final result shows
  a_busy_before_final: assert property (@(posedge clk) disable iff (rst)
    strobe && !final_entry |-> busy)
    else $error("busy dropped before the final result");

  // the final result frees the request side
  a_idle_at_final: assert property (@(posedge clk) disable iff (rst)
    strobe && final_entry |-> !busy)
    else $error("busy still high at the final result");

  // a drain starts only from a request that closes a vector
  a_busy_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && is_last))
    else $error("busy rose without a vector-end request");

endmodule

bind top_n_score_selector_core tnss_checker u_tnss_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .is_last     (is_last),
  .strobe      (strobe),
  .final_entry (final_entry)
);

`default_nettype wire

FILE: tb/sv/tb.sv
// testbench for the top-n score selector: ranking predictor, request driver, result checker
`timescale 1ns / 100ps

module tb;
  import tnss_pkg::*;

  localparam int TABLE_DEPTH   = 8;
  localparam int INDEX_BITS    = 16;
  localparam int RANDOM_ITEMS  = 370;
  localparam int SETTLE_CYCLES = 4;
  localparam int IDLE_LIMIT    = 1000;

  typedef logic [SCORE_W+OUT_INDEX_W-1:0] rank_key_t;

  typedef struct {
    logic [SCORE_W-1:0]     score;
    logic [OUT_INDEX_W-1:0] index;
    logic                   last_one;
  } ranked_entry_t;

  // ranking predictor and store of reported entries still due
  class topn_tracker;
    rank_key_t           kept [TABLE_DEPTH];
    int unsigned         kept_cnt;
    logic [INDEX_BITS-1:0] next_pos;
    logic [KEEP_W-1:0]   keep_reg;
    logic [MIN_W-1:0]    min_reg;
    ranked_entry_t       due_entries[$];
    int unsigned         errors;

    function new();
      kept_cnt = 0;
      next_pos = '0;
      keep_reg = KEEP_COUNT_RESET;
      min_reg  = MIN_SCORE_RESET;
      errors   = 0;
    endfunction

    function void set_reg(reg_idx_t r, logic [APB_DATA_W-1:0] v);
      if (r == REG_KEEP_COUNT) keep_reg = v[KEEP_W-1:0];
      else min_reg = v[MIN_W-1:0];
    endfunction

    function int unsigned eff_keep();
      return (keep_reg > TABLE_DEPTH) ? TABLE_DEPTH : keep_reg;
    endfunction

    // sorted insert, ties go below existing equal keys
    function void rank_insert(rank_key_t key);
      int unsigned k;
      int unsigned p;
      int unsigned i;
      k = eff_keep();
      if (kept_cnt > k) kept_cnt = k;
      if (k == 0) return;
      p = 0;
      while (p < kept_cnt && kept[p] >= key) p++;
      if (kept_cnt < k) begin
        for (i = kept_cnt; i > p; i--) kept[i] = kept[i-1];
        kept[p] = key;
        kept_cnt++;
      end else if (p < kept_cnt) begin
        for (i = kept_cnt - 1; i > p; i--) kept[i] = kept[i-1];
        kept[p] = key;
      end
    endfunction

    // one accepted request: rank it, and on the vector end queue the report
    function void note_score(logic [SCORE_W-1:0] s, logic last);
      int unsigned n;
      int unsigned i;
      ranked_entry_t e;
      if ({1'b0, s} >= min_reg) rank_insert({s, next_pos[OUT_INDEX_W-1:0]});
      next_pos = next_pos + 1'b1;
      if (!last) return;
      n = kept_cnt;
      if (n > eff_keep()) n = eff_keep();
      for (i = 0; i < n; i++) begin
        e.score    = kept[i][SCORE_W+OUT_INDEX_W-1:OUT_INDEX_W];
        e.index    = kept[i][OUT_INDEX_W-1:0];
        e.last_one = (i + 1 == n);
        due_entries = {due_entries, e};
      end
      kept_cnt = 0;
      next_pos = '0;
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    // compare one strobed result with the oldest due entry
    task check_entry(logic [SCORE_W-1:0] s, logic [OUT_INDEX_W-1:0] idx, logic fin);
      ranked_entry_t e;
      if (due_entries.size() == 0) begin
        report_mismatch($sformatf("unexpected result score %0d index %0d", s, idx));
        return;
      end
      e = due_entries.pop_front();
      if (s !== e.score)
        report_mismatch($sformatf("top_score %0d, wanted %0d", s, e.score));
      if (idx !== e.index)
        report_mismatch($sformatf("class_index %0d, wanted %0d", idx, e.index));
      if (fin !== e.last_one)
        report_mismatch($sformatf("final_entry %0b, wanted %0b (index %0d)",
                                  fin, e.last_one, e.index));
    endtask
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  logic [SCORE_W-1:0]        score = '0;
  logic                      is_last = 1'b0;
  logic                      strobe;
  logic [SCORE_W-1:0]        top_score;
  logic [OUT_INDEX_W-1:0]    class_index;
  logic                      final_entry;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]     paddr = '0;
  logic [APB_DATA_W-1:0]     pwdata = '0;
  logic [APB_DATA_W-1:0]     prdata;
  logic                      pready;

  topn_tracker sb;
  bit          no_gaps = 1'b0;
  int unsigned idle_cycles = 0;

  top_n_score_selector_core #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .INDEX_BITS (INDEX_BITS)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .score      (score),
    .is_last    (is_last),
    .strobe     (strobe),
    .top_score  (top_score),
    .class_index(class_index),
    .final_entry(final_entry),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // monitor: results first, then the request taken at this edge
  always @(posedge clk) begin
    if (!rst) begin
      if (strobe === 1'b1) sb.check_entry(top_score, class_index, final_entry);
      if (start && busy === 1'b0) sb.note_score(score, is_last);
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (start && busy === 1'b0) || strobe === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one request, with a random hold-off before it
  task automatic send_score(input logic [SCORE_W-1:0] s, input logic last);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    score   <= s;
    is_last <= last;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  // stop requests and wait until every due entry has come out
  task automatic drain_and_settle();
    start <= 1'b0;
    repeat (2) @(posedge clk);
    while (sb.due_entries.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb transfer: setup, access, then back to idle
  task automatic apb_xfer(input reg_idx_t r, input logic wr, input logic [APB_DATA_W-1:0] v,
                          output logic [APB_DATA_W-1:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // write both registers, optionally with noise in the unused bits, and read them back
  task automatic set_config(input logic [KEEP_W-1:0] k, input logic [MIN_W-1:0] m,
                            input bit junk);
    logic [APB_DATA_W-1:0] v;
    logic [APB_DATA_W-1:0] rd;
    v = junk ? (($urandom() & ~32'hF) | k) : k;
    apb_xfer(REG_KEEP_COUNT, 1'b1, v, rd);
    sb.set_reg(REG_KEEP_COUNT, v);
    v = junk ? (($urandom() & ~32'h1FF) | m) : m;
    apb_xfer(REG_MIN_SCORE, 1'b1, v, rd);
    sb.set_reg(REG_MIN_SCORE, v);
    apb_xfer(REG_KEEP_COUNT, 1'b0, '0, rd);
    if (rd[KEEP_W-1:0] !== sb.keep_reg)
      sb.report_mismatch($sformatf("keep_count read %0d, wanted %0d",
                                   rd[KEEP_W-1:0], sb.keep_reg));
    apb_xfer(REG_MIN_SCORE, 1'b0, '0, rd);
    if (rd[MIN_W-1:0] !== sb.min_reg)
      sb.report_mismatch($sformatf("min_score read %0d, wanted %0d",
                                   rd[MIN_W-1:0], sb.min_reg));
  endtask

  function automatic logic [KEEP_W-1:0] pick_keep();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return KEEP_W'($urandom_range(9, 15));
      2:       return KEEP_W'(TABLE_DEPTH);
      3:       return KEEP_W'(1);
      default: return KEEP_W'($urandom_range(1, TABLE_DEPTH));
    endcase
  endfunction

  function automatic logic [MIN_W-1:0] pick_min();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return MIN_W'(256);
      2:       return MIN_W'($urandom_range(257, 511));
      3:       return MIN_W'(255);
      default: return MIN_W'($urandom_range(1, 200));
    endcase
  endfunction

  // score shapes: full range, heavy ties, around the threshold, all below it
  function automatic logic [SCORE_W-1:0] pick_score(int mode, int base);
    int t;
    int v;
    t = (sb.min_reg > 255) ? 255 : int'(sb.min_reg);
    case (mode)
      1: begin
        case ($urandom_range(0, 2))
          0:       v = base;
          1:       v = 255;
          default: v = t;
        endcase
      end
      2: v = t + int'($urandom_range(0, 4)) - 2;
      3: v = (sb.min_reg == 0) ? int'($urandom_range(0, 255))
                               : int'($urandom_range(0, t - 1));
      default: v = $urandom_range(0, 255);
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return SCORE_W'(v);
  endfunction

  initial begin
    int unsigned rand_items;
    int unsigned len;
    int unsigned cut_at;
    int unsigned j;
    int          mode;
    int          base;

    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values, ties on the threshold, later index wins
    send_score(8'd25, 1'b0);
    send_score(8'd26, 1'b0);
    send_score(8'd255, 1'b0);
    send_score(8'd0, 1'b0);
    send_score(8'd26, 1'b0);
    send_score(8'd128, 1'b1);
    // single-score vector
    send_score(8'd255, 1'b1);
    // empty set, nothing passes
    send_score(8'd10, 1'b0);
    send_score(8'd5, 1'b1);

    // keep count above depth saturates, eviction of the weakest
    drain_and_settle();
    set_config(4'd15, 9'd0, 1'b0);
    send_score(8'd0, 1'b0);
    send_score(8'd255, 1'b0);
    send_score(8'd170, 1'b0);
    send_score(8'd85, 1'b0);
    send_score(8'd1, 1'b0);
    send_score(8'd128, 1'b0);
    send_score(8'd0, 1'b0);
    send_score(8'd255, 1'b0);
    send_score(8'd64, 1'b1);

    // keep count zero
    drain_and_settle();
    set_config(4'd0, 9'd0, 1'b0);
    send_score(8'd200, 1'b1);

    // threshold 256, nothing passes
    drain_and_settle();
    set_config(4'd8, 9'd256, 1'b0);
    send_score(8'd255, 1'b1);

    // keep count lowered in the middle of a vector
    drain_and_settle();
    set_config(4'd8, 9'd0, 1'b0);
    send_score(8'd200, 1'b0);
    send_score(8'd90, 1'b0);
    send_score(8'd255, 1'b0);
    drain_and_settle();
    set_config(4'd2, 9'd0, 1'b0);
    send_score(8'd100, 1'b1);

    // random vectors
    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        drain_and_settle();
        set_config(pick_keep(), pick_min(), 1'b1);
      end
      no_gaps = ($urandom_range(0, 3) == 0);
      len     = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
      mode    = $urandom_range(0, 5);
      base    = $urandom_range(0, 255);
      cut_at  = (len > 1 && $urandom_range(0, 7) == 0) ? $urandom_range(1, len - 1) : 0;
      for (j = 0; j < len; j++) begin
        if (cut_at != 0 && j == cut_at) begin
          drain_and_settle();
          set_config(KEEP_W'($urandom_range(0, sb.keep_reg)), sb.min_reg, 1'b1);
        end
        send_score(pick_score(mode, base), j == len - 1);
        rand_items++;
      end
    end

    drain_and_settle();
    if (sb.due_entries.size() != 0)
      sb.report_mismatch($sformatf("%0d entries never reported", sb.due_entries.size()));
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/tnss_pkg.sv
rtl/core/tnss_cfg.sv
rtl/core/tnss_table.sv
rtl/core/tnss_drain.sv
rtl/core/top_n_score_selector_core.sv
rtl/core/tnss_checker.sv
tb/sv/tb.sv
